// File: hw/rtl/dgbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgbs_pkg
// Shared constants and types of the elevation grid bilinear sampler.
// ----------------------------------------------------------------------------
package dgbs_pkg;

   // Grid points per side that the memory is sized for
   localparam int GRID_DIM   = 64;
   localparam int IDX_W      = $clog2(GRID_DIM);
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int GRID_CELLS = GRID_DIM * GRID_DIM;

   // Field widths
   localparam int OPC_W    = 1;
   localparam int CELL_W   = 12;
   localparam int HEIGHT_W = 16;
   localparam int COORD_W  = 20;
   localparam int GS_W     = 7;
   localparam int FRAC_W   = 16;

   // Q3.16 one, and clamped coordinate width
   localparam int ONE_Q16  = 1 << FRAC_W;
   localparam int CLAMP_W  = FRAC_W + 1;
   localparam int SCALED_W = CLAMP_W + IDX_W;

   // Grid size register reset value
   localparam logic [GS_W-1:0] GS_RESET = GS_W'(GRID_DIM);

   // Request opcodes
   localparam logic [OPC_W-1:0] OP_WRITE  = 1'b0;
   localparam logic [OPC_W-1:0] OP_SAMPLE = 1'b1;

   typedef logic signed [HEIGHT_W-1:0] height_type;
   typedef logic [IDX_W-1:0]           idx_type;
   typedef logic [FRAC_W-1:0]          frac_type;
   typedef logic [ADDR_W-1:0]          addr_type;

   // Floor cell, clamped neighbour and fraction of one coordinate
   typedef struct packed {
      idx_type  i0;
      idx_type  i1;
      frac_type frac;
   } coord_type;

endpackage
`default_nettype wire

// File: hw/rtl/dem_grid_bilinear_sampler_unit.sv
`default_nettype none
// A sample request's result passes through the stage registers and the output register before it shows on rsp_.
// Throughput: one request per cycle unless stalled; the four corner heights come
//   from four banked copies of the grid read in the same cycle, one write port each.
// Grid writes give no response and reach all four banks in request order.
// Reset: synchronous, clears the pipeline valids and sets grid_size to 64;
//   the grid memory is not cleared and is undefined until written.
// ----------------------------------------------------------------------------
// dem_grid_bilinear_sampler_unit
// Clamp and scale, corner addressing with banked reads, two X lerps, one Y lerp.
// ----------------------------------------------------------------------------
module dem_grid_bilinear_sampler_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [dgbs_pkg::OPC_W-1:0]           req_opcode,
   input  wire  [dgbs_pkg::CELL_W-1:0]          req_cell_index,
   input  wire  signed [dgbs_pkg::HEIGHT_W-1:0] req_cell_height,
   input  wire  signed [dgbs_pkg::COORD_W-1:0]  req_norm_x,
   input  wire  signed [dgbs_pkg::COORD_W-1:0]  req_norm_y,
   // response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [dgbs_pkg::HEIGHT_W-1:0] rsp_sampled_height,
   // grid size register
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [dgbs_pkg::GS_W-1:0]            csr_data
);

   localparam int HW   = dgbs_pkg::HEIGHT_W;
   localparam int IW   = dgbs_pkg::IDX_W;
   localparam int FW   = dgbs_pkg::FRAC_W;
   localparam int GW   = dgbs_pkg::GS_W;
   localparam int AW   = dgbs_pkg::ADDR_W;
   localparam int DW   = HW + 1;          // corner difference
   localparam int PW   = DW + FW + 1;     // difference times fraction
   localparam int QW   = PW - FW;         // product after the floor shift

   // ---------------------------------------------------------------
   // Grid size register
   // ---------------------------------------------------------------
   logic [GW-1:0] gs_ff;
   logic [GW-1:0] gs_eff;
   dgbs_pkg::idx_type gm1;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff <= dgbs_pkg::GS_RESET;
      end else if (csr_valid && csr_ready) begin
         gs_ff <= csr_data;
      end
   end

   always_comb begin
      if (gs_ff < GW'(2)) begin
         gs_eff = GW'(2);
      end else if (gs_ff > GW'(dgbs_pkg::GRID_DIM)) begin
         gs_eff = GW'(dgbs_pkg::GRID_DIM);
      end else begin
         gs_eff = gs_ff;
      end
   end

   assign gm1 = IW'(gs_eff - GW'(1));

   // ---------------------------------------------------------------
   // Stage readiness: a stage takes new data when empty or draining
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

   assign rdy_o = !vo_ff || !rsp_stall;
   assign rdy5  = !v5_ff || rdy_o;
   assign rdy4  = !v4_ff || rdy5;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;

   assign req_stall = !rdy1;

   // ---------------------------------------------------------------
   // Stage 1: clamp to 0..1 and scale by grid_size-1
   // ---------------------------------------------------------------
   function automatic dgbs_pkg::coord_type split_coord(
      input logic signed [dgbs_pkg::COORD_W-1:0] n,
      input dgbs_pkg::idx_type                   m1
   );
      logic [dgbs_pkg::CLAMP_W-1:0]  c;
      logic [dgbs_pkg::SCALED_W-1:0] g;
      logic [dgbs_pkg::IDX_W:0]      nxt;
      dgbs_pkg::coord_type           r;
      if (n < 0) begin
         c = '0;
      end else if (n > dgbs_pkg::COORD_W'(dgbs_pkg::ONE_Q16)) begin
         c = dgbs_pkg::CLAMP_W'(dgbs_pkg::ONE_Q16);
      end else begin
         c = n[dgbs_pkg::CLAMP_W-1:0];
      end
      g      = dgbs_pkg::SCALED_W'(c) * dgbs_pkg::SCALED_W'(m1);
      r.i0   = g[dgbs_pkg::FRAC_W +: dgbs_pkg::IDX_W];
      r.frac = g[dgbs_pkg::FRAC_W-1:0];
      nxt    = {1'b0, r.i0} + (dgbs_pkg::IDX_W+1)'(1);
      // hold the neighbour at the last index
      r.i1   = (nxt < {1'b0, m1}) ? nxt[dgbs_pkg::IDX_W-1:0] : m1;
      return r;
   endfunction

   logic                          req_acc;
   dgbs_pkg::coord_type           cx_in, cy_in;
   dgbs_pkg::coord_type           cx1_ff, cy1_ff;
   logic [dgbs_pkg::OPC_W-1:0]    op1_ff;
   logic [dgbs_pkg::CELL_W-1:0]   widx1_ff;
   dgbs_pkg::height_type          wdat1_ff;

   assign req_acc = req_valid && !req_stall;
   assign cx_in   = split_coord(req_norm_x, gm1);
   assign cy_in   = split_coord(req_norm_y, gm1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op1_ff   <= req_opcode;
         widx1_ff <= req_cell_index;
         wdat1_ff <= req_cell_height;
         cx1_ff   <= cx_in;
         cy1_ff   <= cy_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: corner addresses and banked grid access
   // ---------------------------------------------------------------
   logic     adv1, wr_en, rd_en;
   logic [AW+GW-1:0] row0_mul, row1_mul;
   dgbs_pkg::addr_type a00, a01, a10, a11;

   assign adv1  = v1_ff && rdy2;
   assign rd_en = adv1 && (op1_ff == dgbs_pkg::OP_SAMPLE);
   assign wr_en = adv1 && (op1_ff == dgbs_pkg::OP_WRITE) &&
                  ({1'b0, widx1_ff} < (dgbs_pkg::CELL_W+1)'(dgbs_pkg::GRID_CELLS));

   assign row0_mul = (AW+GW)'(cy1_ff.i0) * (AW+GW)'(gs_eff);
   assign row1_mul = (AW+GW)'(cy1_ff.i1) * (AW+GW)'(gs_eff);
   assign a00 = AW'(row0_mul + (AW+GW)'(cx1_ff.i0));
   assign a01 = AW'(row0_mul + (AW+GW)'(cx1_ff.i1));
   assign a10 = AW'(row1_mul + (AW+GW)'(cx1_ff.i0));
   assign a11 = AW'(row1_mul + (AW+GW)'(cx1_ff.i1));

   // one full copy of the grid per corner
   dgbs_pkg::height_type bank00_ff [0:dgbs_pkg::GRID_CELLS-1];
   dgbs_pkg::height_type bank01_ff [0:dgbs_pkg::GRID_CELLS-1];
   dgbs_pkg::height_type bank10_ff [0:dgbs_pkg::GRID_CELLS-1];
   dgbs_pkg::height_type bank11_ff [0:dgbs_pkg::GRID_CELLS-1];
   dgbs_pkg::height_type q00_ff, q01_ff, q10_ff, q11_ff;
   dgbs_pkg::addr_type   waddr;

   assign waddr = widx1_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank00_ff[waddr] <= wdat1_ff;
         bank01_ff[waddr] <= wdat1_ff;
         bank10_ff[waddr] <= wdat1_ff;
         bank11_ff[waddr] <= wdat1_ff;
      end
      if (rd_en) begin
         q00_ff <= bank00_ff[a00];
         q01_ff <= bank01_ff[a01];
         q10_ff <= bank10_ff[a10];
         q11_ff <= bank11_ff[a11];
      end
   end

   dgbs_pkg::frac_type fx2_ff, fy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fx2_ff <= cx1_ff.frac;
         fy2_ff <= cy1_ff.frac;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: X differences times fraction
   // ---------------------------------------------------------------
   logic signed [DW-1:0] dt, db;
   logic signed [PW-1:0] pt_in, pb_in, pt3_ff, pb3_ff;
   dgbs_pkg::height_type at3_ff, ab3_ff;
   dgbs_pkg::frac_type   fy3_ff;

   assign dt    = DW'(q01_ff) - DW'(q00_ff);
   assign db    = DW'(q11_ff) - DW'(q10_ff);
   assign pt_in = PW'(dt) * PW'($signed({1'b0, fx2_ff}));
   assign pb_in = PW'(db) * PW'($signed({1'b0, fx2_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         pt3_ff <= pt_in;
         pb3_ff <= pb_in;
         at3_ff <= q00_ff;
         ab3_ff <= q10_ff;
         fy3_ff <= fy2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: finish the X lerps (floor shift)
   // ---------------------------------------------------------------
   logic signed [QW-1:0] top_sum, bot_sum;
   dgbs_pkg::height_type top4_ff, bot4_ff;
   dgbs_pkg::frac_type   fy4_ff;

   assign top_sum = QW'(at3_ff) + pt3_ff[PW-1:FW];
   assign bot_sum = QW'(ab3_ff) + pb3_ff[PW-1:FW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         top4_ff <= top_sum[HW-1:0];
         bot4_ff <= bot_sum[HW-1:0];
         fy4_ff  <= fy3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: Y difference times fraction
   // ---------------------------------------------------------------
   logic signed [DW-1:0] dy;
   logic signed [PW-1:0] py_in, py5_ff;
   dgbs_pkg::height_type top5_ff;

   assign dy    = DW'(bot4_ff) - DW'(top4_ff);
   assign py_in = PW'(dy) * PW'($signed({1'b0, fy4_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (rdy5) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         py5_ff  <= py_in;
         top5_ff <= top4_ff;
      end
   end

   // ---------------------------------------------------------------
   // Output register: finish the Y lerp
   // ---------------------------------------------------------------
   logic signed [QW-1:0] res_sum;
   dgbs_pkg::height_type res_ff;

   assign res_sum = QW'(top5_ff) + py5_ff[PW-1:FW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (rdy_o) begin
         vo_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_o && v5_ff) begin
         res_ff <= res_sum[HW-1:0];
      end
   end

   assign rsp_valid          = vo_ff;
   assign rsp_sampled_height = res_ff;

endmodule
`default_nettype wire

// File: dv/dem_grid_bilinear_sampler_unit_test.sv
// ----------------------------------------------------------------------------
// dem_grid_bilinear_sampler_unit_test
// Streams grid writes and sample requests into the sampler, keeps a local copy
// of the grid, predicts each bilinear blend and checks responses in order over
// several grid sizes and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module dem_grid_bilinear_sampler_unit_test;

   localparam int PIPE_SLACK  = 12;
   localparam int DRAIN_LIMIT = 20000;
   localparam int PHASE_ITEMS = 190;
   localparam int NUM_PHASES  = 9;
   localparam int MAX_REPORTS = 10;

   typedef enum int {LOAD_NONE, LOAD_SENDER, LOAD_RECEIVER, LOAD_BOTH} load_mode_type;

   typedef struct packed {
      logic [dgbs_pkg::OPC_W-1:0]           opcode;
      logic [dgbs_pkg::CELL_W-1:0]          cell_idx;
      logic signed [dgbs_pkg::HEIGHT_W-1:0] height;
      logic signed [dgbs_pkg::COORD_W-1:0]  nx;
      logic signed [dgbs_pkg::COORD_W-1:0]  ny;
      logic                                 fixed_answer;
      logic signed [dgbs_pkg::HEIGHT_W-1:0] answer;
   } grid_req_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [dgbs_pkg::OPC_W-1:0]           req_opcode = dgbs_pkg::OP_WRITE;
   logic [dgbs_pkg::CELL_W-1:0]          req_cell_index = '0;
   logic signed [dgbs_pkg::HEIGHT_W-1:0] req_cell_height = '0;
   logic signed [dgbs_pkg::COORD_W-1:0]  req_norm_x = '0;
   logic signed [dgbs_pkg::COORD_W-1:0]  req_norm_y = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [dgbs_pkg::HEIGHT_W-1:0] rsp_sampled_height;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [dgbs_pkg::GS_W-1:0]            csr_data = dgbs_pkg::GS_RESET;

   dgbs_pkg::height_type grid_model [dgbs_pkg::GRID_CELLS];
   bit                   cell_written [dgbs_pkg::GRID_CELLS];
   int                   side_len = dgbs_pkg::GRID_DIM;
   dgbs_pkg::height_type pending_heights [$];
   grid_req_type         directed_rows [$];
   int                   mismatch_count = 0;
   int                   sent_count = 0;
   int                   sender_idle_pct = 0;
   int                   receiver_stall_pct = 0;

   dem_grid_bilinear_sampler_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_cell_index     (req_cell_index),
      .req_cell_height    (req_cell_height),
      .req_norm_x         (req_norm_x),
      .req_norm_y         (req_norm_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sampled_height (rsp_sampled_height),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic int clip_side(input logic [dgbs_pkg::GS_W-1:0] value);
      int n;
      n = value;
      if (n < 2) return 2;
      if (n > dgbs_pkg::GRID_DIM) return dgbs_pkg::GRID_DIM;
      return n;
   endfunction

   // Clamp to 0..1, scale by side-1, split into floor cell, neighbor and fraction
   function automatic void split_axis(input logic signed [dgbs_pkg::COORD_W-1:0] coord,
                                      output int lo, output int hi, output int frac);
      int c;
      int g;
      c = (coord < 0) ? 0 :
          ((coord > dgbs_pkg::ONE_Q16) ? dgbs_pkg::ONE_Q16 : int'(coord));
      g = c * (side_len - 1);
      lo = g >> dgbs_pkg::FRAC_W;
      frac = g & (dgbs_pkg::ONE_Q16 - 1);
      hi = (lo + 1 < side_len - 1) ? lo + 1 : side_len - 1;
   endfunction

   // a + floor((b - a) * frac / 2^16)
   function automatic int lerp_floor(input int a, input int b, input int frac);
      longint p;
      p = longint'(b - a) * longint'(frac);
      return a + int'(p >>> dgbs_pkg::FRAC_W);
   endfunction

   function automatic dgbs_pkg::height_type blend_height(
      input logic signed [dgbs_pkg::COORD_W-1:0] nx,
      input logic signed [dgbs_pkg::COORD_W-1:0] ny);
      int x0, x1, fx, y0, y1, fy, top, bot;
      split_axis(nx, x0, x1, fx);
      split_axis(ny, y0, y1, fy);
      top = lerp_floor(grid_model[y0 * side_len + x0], grid_model[y0 * side_len + x1], fx);
      bot = lerp_floor(grid_model[y1 * side_len + x0], grid_model[y1 * side_len + x1], fx);
      return dgbs_pkg::height_type'(lerp_floor(top, bot, fy));
   endfunction

   function automatic void note_request(input grid_req_type r);
      if (r.opcode == dgbs_pkg::OP_WRITE) begin
         grid_model[r.cell_idx] = r.height;
         cell_written[r.cell_idx] = 1'b1;
      end else begin
         pending_heights.push_back(r.fixed_answer ? r.answer : blend_height(r.nx, r.ny));
      end
   endfunction

   function automatic void report_miss(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   function automatic void add_row(input logic [dgbs_pkg::OPC_W-1:0] op, input int idx,
                                   input int height, input int nx, input int ny,
                                   input bit fixed_answer, input int answer);
      grid_req_type r;
      r.opcode = op;
      r.cell_idx = idx[dgbs_pkg::CELL_W-1:0];
      r.height = height[dgbs_pkg::HEIGHT_W-1:0];
      r.nx = nx[dgbs_pkg::COORD_W-1:0];
      r.ny = ny[dgbs_pkg::COORD_W-1:0];
      r.fixed_answer = fixed_answer;
      r.answer = answer[dgbs_pkg::HEIGHT_W-1:0];
      directed_rows.push_back(r);
   endfunction

   function automatic int pick_height();
      case ($urandom_range(7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return int'($urandom);
      endcase
   endfunction

   function automatic int pick_coord();
      case ($urandom_range(9))
         0: return 0;
         1: return dgbs_pkg::ONE_Q16;
         2: return int'($urandom_range(dgbs_pkg::ONE_Q16 + 1, 524287));
         3: return -int'($urandom_range(1, 524288));
         4: return int'($urandom);
         default: return int'($urandom_range(dgbs_pkg::ONE_Q16));
      endcase
   endfunction

   task automatic set_load(input load_mode_type mode);
      case (mode)
         LOAD_NONE: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         LOAD_SENDER: begin
            sender_idle_pct = 80;
            receiver_stall_pct = 0;
         end
         LOAD_RECEIVER: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 80;
         end
         default: begin
            sender_idle_pct = 9;
            receiver_stall_pct = 9;
         end
      endcase
   endtask

   task automatic send_request(input grid_req_type r);
      // drop valid for a random idle gap before the request
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_opcode      <= r.opcode;
      req_cell_index  <= r.cell_idx;
      req_cell_height <= r.height;
      req_norm_x      <= r.nx;
      req_norm_y      <= r.ny;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      note_request(r);
      sent_count++;
   endtask

   task automatic write_cell(input int idx, input int height);
      grid_req_type r;
      r = '0;
      r.opcode = dgbs_pkg::OP_WRITE;
      r.cell_idx = idx[dgbs_pkg::CELL_W-1:0];
      r.height = height[dgbs_pkg::HEIGHT_W-1:0];
      r.nx = dgbs_pkg::COORD_W'($urandom);
      r.ny = dgbs_pkg::COORD_W'($urandom);
      send_request(r);
   endtask

   task automatic random_write();
      int idx;
      if ($urandom_range(1) == 1)
         idx = $urandom_range(side_len - 1) * side_len + $urandom_range(side_len - 1);
      else
         idx = $urandom_range(dgbs_pkg::GRID_CELLS - 1);
      write_cell(idx, pick_height());
   endtask

   task automatic random_sample();
      grid_req_type r;
      int x0, x1, fx, y0, y1, fy;
      int corner [4];
      r = '0;
      r.opcode = dgbs_pkg::OP_SAMPLE;
      r.cell_idx = dgbs_pkg::CELL_W'($urandom);
      r.height = dgbs_pkg::HEIGHT_W'($urandom);
      r.nx = dgbs_pkg::COORD_W'(pick_coord());
      r.ny = dgbs_pkg::COORD_W'(pick_coord());
      split_axis(r.nx, x0, x1, fx);
      split_axis(r.ny, y0, y1, fy);
      corner[0] = y0 * side_len + x0;
      corner[1] = y0 * side_len + x1;
      corner[2] = y1 * side_len + x0;
      corner[3] = y1 * side_len + x1;
      // fill any corner not yet written so no undefined cell is ever read
      foreach (corner[k]) begin
         if (!cell_written[corner[k]]) write_cell(corner[k], pick_height());
      end
      send_request(r);
   endtask

   task automatic write_grid_size(input logic [dgbs_pkg::GS_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      side_len = clip_side(value);
   endtask

   task automatic wait_drained();
      int spins;
      spins = 0;
      req_valid <= 1'b0;
      while (pending_heights.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      // let trailing grid writes settle
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_rsp
      dgbs_pkg::height_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_heights.size() == 0) begin
            report_miss($sformatf("sampled height %0d with no sample request waiting",
                                  rsp_sampled_height));
         end else begin
            want = pending_heights.pop_front();
            if (rsp_sampled_height !== want)
               report_miss($sformatf("sampled height: expected %0d, got %0d",
                                     want, rsp_sampled_height));
         end
      end
   end

   initial begin : stimulus
      logic [dgbs_pkg::GS_W-1:0] phase_side [NUM_PHASES];
      load_mode_type             phase_load [NUM_PHASES];
      int                        first;
      phase_side = '{7'd2, 7'd0, 7'd1, 7'd127, 7'd64, 7'd65, 7'd3, 7'd5, 7'd17};
      phase_load = '{LOAD_NONE, LOAD_SENDER, LOAD_RECEIVER, LOAD_BOTH, LOAD_NONE,
                     LOAD_SENDER, LOAD_RECEIVER, LOAD_BOTH, LOAD_NONE};
      phase_side[6] = dgbs_pkg::GS_W'($urandom_range(3, 63));
      phase_side[8] = dgbs_pkg::GS_W'($urandom_range(6, 63));

      // grid corners, two at the height extremes; unused coordinates carry junk
      add_row(dgbs_pkg::OP_WRITE, 0, -32768, 524287, -524288, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 63, 32767, -524288, 524287, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 4032, -1, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 4095, 1, 0, 0, 0, 0);
      // neighbors that the corner samples read with a zero fraction
      add_row(dgbs_pkg::OP_WRITE, 1, 100, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 64, -100, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 65, 200, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 127, -200, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 4033, 300, 0, 0, 0, 0);
      // coordinates saturating at both ends land exactly on the corners
      add_row(dgbs_pkg::OP_SAMPLE, 4095, -1, -524288, -524288, 1, -32768);
      add_row(dgbs_pkg::OP_SAMPLE, 0, 0, 65536, -1, 1, 32767);
      add_row(dgbs_pkg::OP_SAMPLE, 0, 0, 0, 65536, 1, -1);
      add_row(dgbs_pkg::OP_SAMPLE, 4095, 32767, 524287, 524287, 1, 1);
      add_row(dgbs_pkg::OP_SAMPLE, 63, -32768, -1, 65537, 1, -1);
      // mid-grid cell with full-swing corners at half fraction
      add_row(dgbs_pkg::OP_WRITE, 2015, -32768, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 2016, 32767, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 2079, 32767, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 2080, -32768, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_SAMPLE, 0, 0, 32768, 32768, 0, 0);
      // first cell, fraction near one, negative products along one edge
      add_row(dgbs_pkg::OP_WRITE, 1, 32767, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 64, 32767, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_WRITE, 65, -32768, 0, 0, 0, 0);
      add_row(dgbs_pkg::OP_SAMPLE, 0, 0, 1040, 1040, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_grid_size(phase_side[p]);
         set_load(phase_load[p]);
         first = sent_count;
         while (sent_count - first < PHASE_ITEMS) begin
            if ($urandom_range(99) < 25) random_write();
            else random_sample();
         end
      end

      wait_drained();
      if (pending_heights.size() != 0) begin
         mismatch_count += pending_heights.size();
         $display("%0d sampled heights never returned", pending_heights.size());
      end
      if (mismatch_count == 0) begin
         $display("dem_grid_bilinear_sampler_unit regression: pass");
      end else begin
         $display("dem_grid_bilinear_sampler_unit regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("dem_grid_bilinear_sampler_unit regression: fail");
      $finish;
   end

endmodule
